@@ hdl/tsv_pkg.sv @@
`timescale 1ns / 1ps
// tsv_pkg: shared types and character constants for the time string validator
// no dependencies
package tsv_pkg;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_1       = 8'h31;
   localparam logic [7:0] CH_2       = 8'h32;
   localparam logic [7:0] CH_3       = 8'h33;
   localparam logic [7:0] CH_5       = 8'h35;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   typedef enum logic [3:0] {
      ST_START = 4'd0,
      ST_H1_01 = 4'd1,
      ST_H1_2  = 4'd2,
      ST_H2    = 4'd3,
      ST_COL1  = 4'd4,
      ST_M1    = 4'd5,
      ST_M2    = 4'd6,
      ST_COL2  = 4'd7,
      ST_S1    = 4'd8,
      ST_DONE  = 4'd9,
      ST_BIG   = 4'd10,
      ST_ERR   = 4'd11
   } scan_state_type;

   typedef enum logic [1:0] {
      STATUS_VALID      = 2'd0,
      STATUS_INCOMPLETE = 2'd1,
      STATUS_BAD_CHAR   = 2'd2,
      STATUS_BIG_HOUR   = 2'd3
   } status_type;

   // what one scanned byte produces
   typedef struct packed {
      logic       term;
      status_type status;
   } scan_out_type;

endpackage

@@ hdl/tsv_scan.sv @@
`timescale 1ns / 1ps
// tsv_scan: character-class state machine that walks one byte per step
// depends on tsv_pkg
module tsv_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           ch,
   output tsv_pkg::scan_out_type scan_out
);
   import tsv_pkg::*;

   scan_state_type state_ff, state_in;
   status_type     error_ff, error_in;
   logic           term;
   logic           is_alnum;

   assign term     = (ch == CH_NUL) || (ch == CH_LF);
   assign is_alnum = ch inside {[CH_0:CH_9], [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};

   always_comb begin
      state_in = state_ff;
      error_in = error_ff;
      scan_out.term   = term;
      scan_out.status = error_ff;
      if ((state_ff != ST_DONE) && (error_ff == STATUS_VALID)) begin
         scan_out.status = STATUS_INCOMPLETE;
      end
      if (term) begin
         state_in = ST_START;
         error_in = STATUS_VALID;
      end else begin
         case (state_ff)
            ST_START: begin
               if (ch inside {[CH_0:CH_1]}) state_in = ST_H1_01;
               else if (ch == CH_2)         state_in = ST_H1_2;
               else if (ch inside {[CH_3:CH_9]}) state_in = ST_BIG;
               else begin
                  state_in = ST_ERR;
                  error_in = STATUS_BAD_CHAR;
               end
            end
            ST_H1_01, ST_M1, ST_S1: begin
               if (ch inside {[CH_0:CH_9]}) begin
                  state_in = (state_ff == ST_H1_01) ? ST_H2 :
                             (state_ff == ST_M1) ? ST_M2 : ST_DONE;
               end else begin
                  state_in = ST_ERR;
                  error_in = STATUS_BAD_CHAR;
               end
            end
            ST_H1_2: begin
               if (ch inside {[CH_0:CH_3]}) state_in = ST_H2;
               else begin
                  state_in = ST_ERR;
                  error_in = STATUS_BAD_CHAR;
               end
            end
            ST_H2, ST_M2: begin
               if (ch == CH_COLON) state_in = (state_ff == ST_H2) ? ST_COL1 : ST_COL2;
               else begin
                  state_in = ST_ERR;
                  error_in = STATUS_BAD_CHAR;
               end
            end
            ST_COL1, ST_COL2: begin
               if (ch inside {[CH_0:CH_5]}) state_in = (state_ff == ST_COL1) ? ST_M1 : ST_S1;
               else begin
                  state_in = ST_ERR;
                  error_in = STATUS_BAD_CHAR;
               end
            end
            ST_DONE: begin
               if (is_alnum) begin
                  state_in = ST_ERR;
                  error_in = STATUS_BAD_CHAR;
               end else begin
                  error_in = STATUS_VALID;
               end
            end
            ST_BIG: begin
               state_in = ST_ERR;
               error_in = STATUS_BIG_HOUR;
            end
            default: begin
               // error state: hold until the terminator
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         error_ff <= STATUS_VALID;
      end else if (step) begin
         state_ff <= state_in;
         error_ff <= error_in;
      end
   end

   a_error_only_in_err: assert property (@(posedge clock) disable iff (reset)
      (error_ff != STATUS_VALID) |-> (state_ff == ST_ERR))
      else $error("error code recorded outside error state");

   a_term_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && term) |=> (state_ff == ST_START) && (error_ff == STATUS_VALID))
      else $error("terminator did not restart the scan");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff) && $stable(error_ff))
      else $error("scan state moved without an item");

endmodule

@@ hdl/time_string_validator.sv @@
`timescale 1ns / 1ps
// time_string_validator: checks byte streams against the 24-hour HH:MM:SS form
// depends on tsv_pkg and tsv_scan
// a status item appears in the cycle after its terminator byte is accepted
// throughput: one byte per cycle while the status register is empty or drains; the scan
// state advances in the same cycle as the byte is taken, and the status register holds a
// result until taken; only terminator bytes (0 or newline) produce a status item
// reset: synchronous, clears the scan to its start state and empties the status register
module time_string_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] status, [7:2] zero
);
   import tsv_pkg::*;

   logic         req_fire;
   scan_out_type scan_out;
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   status_ff, status_in;

   // a new byte may enter whenever the status register is empty or drains now
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   tsv_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (req_fire),
      .ch       (req_tdata),
      .scan_out (scan_out)
   );

   // status register: loads on a terminator item, clears when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire && scan_out.term) begin
         rsp_valid_in = 1'b1;
         status_in    = scan_out.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, status_ff};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(status_ff))
      else $error("pending status item was lost or changed");

   a_rsp_from_term: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_tready) && !(req_fire && scan_out.term) |=> !rsp_valid_ff)
      else $error("status item appeared without a terminator");

   a_term_loads: assert property (@(posedge clock) disable iff (reset)
      (req_fire && scan_out.term) |=> rsp_valid_ff)
      else $error("terminator item produced no status");

endmodule

@@ dv/tb_time_string_validator.sv @@
`timescale 1ns / 1ps
// tb_time_string_validator: self-checking bench for the HH:MM:SS string checker
// needs tsv_pkg and time_string_validator; the status of each string is predicted
// per accepted byte and compared with every status item the block returns
module tb_time_string_validator;
   import tsv_pkg::*;

   typedef logic [7:0] ch_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] ch
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [1:0] status, [7:2] zero

   // bytes waiting for the driver, statuses waiting for the block
   ch_type     pending_bytes_q[$];
   status_type expected_status_q[$];

   int unsigned bytes_queued = 0;
   int unsigned bytes_taken  = 0;
   int unsigned fail_count   = 0;

   // idle odds in percent, changed per phase
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // predictor state
   scan_state_type scan_st  = ST_START;
   status_type     err_code = STATUS_VALID;

   bit         got_term;
   status_type got_status;
   status_type want_status;

   time_string_validator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // safety net against a hung handshake
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic bit between(ch_type c, ch_type lo, ch_type hi);
      return c >= lo && c <= hi;
   endfunction

   // ascii letters and digits only; bytes above 127 are not alphanumeric
   function automatic bit is_alnum(ch_type c);
      return between(c, CH_0, CH_9) || between(c, CH_UPPER_A, CH_UPPER_Z) ||
             between(c, CH_LOWER_A, CH_LOWER_Z);
   endfunction

   function automatic void reject(status_type code);
      err_code = code;
      scan_st  = ST_ERR;
   endfunction

   // advance the expected scan by one byte; a terminator yields a status
   function automatic void time_scan_step(input ch_type c, output bit term,
                                          output status_type status);
      term   = (c == CH_NUL) || (c == CH_LF);
      status = err_code;
      if (term) begin
         // no error yet but not at the end of the seconds: string cut short
         if (scan_st != ST_DONE && err_code == STATUS_VALID)
            status = STATUS_INCOMPLETE;
         scan_st  = ST_START;
         err_code = STATUS_VALID;
      end else begin
         case (scan_st)
            ST_START: begin
               if (between(c, CH_0, CH_1))      scan_st = ST_H1_01;
               else if (c == CH_2)              scan_st = ST_H1_2;
               else if (between(c, CH_3, CH_9)) scan_st = ST_BIG;
               else                             reject(STATUS_BAD_CHAR);
            end
            ST_H1_01: begin
               if (between(c, CH_0, CH_9)) scan_st = ST_H2; else reject(STATUS_BAD_CHAR);
            end
            // hour 2x only allows 20..23
            ST_H1_2: begin
               if (between(c, CH_0, CH_3)) scan_st = ST_H2; else reject(STATUS_BAD_CHAR);
            end
            ST_H2: begin
               if (c == CH_COLON) scan_st = ST_COL1; else reject(STATUS_BAD_CHAR);
            end
            ST_COL1: begin
               if (between(c, CH_0, CH_5)) scan_st = ST_M1; else reject(STATUS_BAD_CHAR);
            end
            ST_M1: begin
               if (between(c, CH_0, CH_9)) scan_st = ST_M2; else reject(STATUS_BAD_CHAR);
            end
            ST_M2: begin
               if (c == CH_COLON) scan_st = ST_COL2; else reject(STATUS_BAD_CHAR);
            end
            ST_COL2: begin
               if (between(c, CH_0, CH_5)) scan_st = ST_S1; else reject(STATUS_BAD_CHAR);
            end
            ST_S1: begin
               if (between(c, CH_0, CH_9)) scan_st = ST_DONE; else reject(STATUS_BAD_CHAR);
            end
            // trailing bytes after a full time must not be letters or digits
            ST_DONE: begin
               if (is_alnum(c)) reject(STATUS_BAD_CHAR); else err_code = STATUS_VALID;
            end
            // a large first hour digit fails on whatever byte follows it
            ST_BIG: reject(STATUS_BIG_HOUR);
            default: ;   // error: swallow bytes until the terminator
         endcase
      end
   endfunction

   // any byte except a terminator
   function automatic ch_type body_byte();
      ch_type c;
      do
         c = ch_type'($urandom_range(255));
      while (c == CH_NUL || c == CH_LF);
      return c;
   endfunction

   function automatic ch_type digit_upto(int unsigned hi);
      return ch_type'(CH_0 + $urandom_range(hi));
   endfunction

   task automatic queue_byte(ch_type c);
      pending_bytes_q.push_back(c);
      bytes_queued++;
   endtask

   task automatic queue_text(string s);
      for (int i = 0; i < s.len(); i++)
         queue_byte(ch_type'(s[i]));
   endtask

   // one random string plus its terminator; mostly well-formed times so the
   // scan gets past the hour, with cuts, corrupted bytes and junk mixed in
   task automatic queue_random_string();
      ch_type      txt[$];
      ch_type      h1;
      ch_type      c;
      int unsigned kind;
      int unsigned pick;
      int unsigned pos;
      kind = $urandom_range(99);
      if (kind < 65) begin
         h1 = digit_upto(2);
         txt.push_back(h1);
         txt.push_back(h1 == CH_2 ? digit_upto(3) : digit_upto(9));
         txt.push_back(CH_COLON);
         txt.push_back(digit_upto(5));
         txt.push_back(digit_upto(9));
         txt.push_back(CH_COLON);
         txt.push_back(digit_upto(5));
         txt.push_back(digit_upto(9));
         repeat ($urandom_range(3)) begin
            c = body_byte();
            if ($urandom_range(3) != 0)
               while (is_alnum(c)) c = body_byte();
            txt.push_back(c);
         end
         pick = $urandom_range(99);
         if (pick < 15) begin
            // cut short, possibly down to nothing
            pos = $urandom_range(txt.size() - 1);
            while (txt.size() > pos) void'(txt.pop_back());
         end else if (pick < 40) begin
            pos = $urandom_range(txt.size() - 1);
            case ($urandom_range(2))
               0: txt[pos] = digit_upto(9);
               1: txt[pos] = CH_COLON;
               default: txt[pos] = body_byte();
            endcase
         end
      end else if (kind < 80) begin
         repeat ($urandom_range(6)) txt.push_back(body_byte());
      end else begin
         // first hour digit 3..9
         txt.push_back(ch_type'(CH_3 + $urandom_range(6)));
         repeat ($urandom_range(3)) txt.push_back(body_byte());
      end
      txt.push_back($urandom_range(1) ? CH_LF : CH_NUL);
      foreach (txt[i]) queue_byte(txt[i]);
   endtask

   // hold the sender until every byte is taken and every status has come back
   task automatic drain();
      while (bytes_taken != bytes_queued || expected_status_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                            int unsigned n_bytes);
      int unsigned start_count;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start_count    = bytes_queued;
      while (bytes_queued - start_count < n_bytes)
         queue_random_string();
      drain();
   endtask

   // stimulus
   initial begin
      // full time at the upper limits, then a high byte and a space as trailers
      queue_text("23:59:59");
      queue_byte(8'hFF);
      queue_text(" ");
      queue_byte(CH_LF);
      // empty string
      queue_byte(CH_NUL);
      // large hour digit ended right away
      queue_text("9");
      queue_byte(CH_LF);
      // large hour digit followed by a byte
      queue_text("3x");
      queue_byte(CH_NUL);
      // early end after one hour digit
      queue_text("1");
      queue_byte(CH_NUL);
      // bad second digit after a 2, later bytes ignored
      queue_text("2a5");
      queue_byte(CH_LF);
      wait (reset == 1'b0);
      drain();

      run_phase(0, 0, 400);
      run_phase(72, 0, 420);
      run_phase(0, 72, 420);
      run_phase(18, 18, 420);

      // let any stray status item show up before the verdict
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // driver: a byte is only replaced once the current one has been taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_bytes_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predict on accepted bytes, check accepted status items
   always @(posedge clock) begin
      if (reset) begin
         scan_st  = ST_START;
         err_code = STATUS_VALID;
      end else begin
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            time_scan_step(req_tdata, got_term, got_status);
            if (got_term) expected_status_q.push_back(got_status);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status_q.size() == 0) begin
               $error("unexpected status item, rsp_tdata 0x%02h", rsp_tdata);
               fail_count++;
            end else begin
               want_status = expected_status_q.pop_front();
               if (rsp_tdata[1:0] != want_status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want_status, rsp_tdata[1:0]);
                  fail_count++;
               end
               if (rsp_tdata[7:2] != 6'd0) begin
                  $error("tdata pad mismatch: expected 0, actual %0d", rsp_tdata[7:2]);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

@@ files.f @@
hdl/tsv_pkg.sv
hdl/tsv_scan.sv
hdl/time_string_validator.sv
dv/tb_time_string_validator.sv
